// ===== hw/rtl/cau_pkg.sv =====
// Package with the constants, types and helper functions of the complex arithmetic unit.
package cau_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int QUO_BITS  = DATA_W;
  localparam int DIV_SHIFT = QUO_BITS - FRAC_BITS;
  localparam int WIDE_W    = PROD_W + QUO_BITS;
  localparam int LATENCY   = 6 + QUO_BITS;

  // Opcodes.
  localparam logic [2:0] OP_ADD      = 3'd0;
  localparam logic [2:0] OP_SUB      = 3'd1;
  localparam logic [2:0] OP_MUL      = 3'd2;
  localparam logic [2:0] OP_SCALE    = 3'd3;
  localparam logic [2:0] OP_DIV_REAL = 3'd4;
  localparam logic [2:0] OP_DIV_CPLX = 3'd5;
  localparam logic [2:0] OP_CONJ     = 3'd6;
  localparam logic [2:0] OP_MOD_SQ   = 3'd7;

  // How a result part is finished.
  localparam logic [1:0] MODE_CLIP  = 2'd0;
  localparam logic [1:0] MODE_SCALE = 2'd1;
  localparam logic [1:0] MODE_DIV   = 2'd2;

  typedef struct packed {
    logic              sat;
    logic [DATA_W-1:0] val;
  } clip_t;

  // One result part on its way through the divider.
  typedef struct packed {
    logic                neg;
    logic                presat;
    logic                sat;
    logic [DATA_W-1:0]   res;
    logic [PROD_W-1:0]   rem;
    logic [QUO_BITS-1:0] quo;
    logic [QUO_BITS-1:0] low;
  } part_t;

  typedef struct packed {
    logic              dz;
    logic              is_div;
    logic [PROD_W-1:0] den;
    part_t             re;
    part_t             im;
  } div_stage_t;

  // Saturate a sign and magnitude to the signed data range.
  function automatic clip_t clip_mag(input logic neg, input logic [PROD_W:0] mag);
    clip_t             c;
    logic [PROD_W:0]   lim;
    logic [PROD_W:0]   m;
    lim   = neg ? ((PROD_W+1)'(1) << (DATA_W - 1))
                : (((PROD_W+1)'(1) << (DATA_W - 1)) - (PROD_W+1)'(1));
    m     = mag;
    c.sat = 1'b0;
    if (mag > lim) begin
      m     = lim;
      c.sat = 1'b1;
    end
    c.val = neg ? (~m[DATA_W-1:0] + DATA_W'(1)) : m[DATA_W-1:0];
    return c;
  endfunction

  // One restoring division step on one result part.
  function automatic part_t part_step(input part_t p, input logic [PROD_W-1:0] den);
    part_t           n;
    logic [PROD_W:0] t;
    logic            ge;
    n     = p;
    t     = {p.rem, p.low[QUO_BITS-1]};
    ge    = (t >= {1'b0, den});
    n.rem = ge ? PROD_W'(t - {1'b0, den}) : t[PROD_W-1:0];
    n.quo = {p.quo[QUO_BITS-2:0], ge};
    n.low = {p.low[QUO_BITS-2:0], 1'b0};
    return n;
  endfunction

  function automatic div_stage_t div_step(input div_stage_t s);
    div_stage_t n;
    n    = s;
    n.re = part_step(s.re, s.den);
    n.im = part_step(s.im, s.den);
    return n;
  endfunction

  // Round the quotient and saturate, or pass the early result.
  function automatic clip_t part_finish(input part_t p, input logic is_div,
                                        input logic [PROD_W-1:0] den);
    clip_t             c;
    logic              rnd;
    logic [QUO_BITS:0] q1;
    logic [PROD_W:0]   mag;
    rnd = ({1'b0, p.rem, 1'b0} >= {2'b00, den});
    q1  = {1'b0, p.quo} + (QUO_BITS+1)'(rnd);
    mag = p.presat ? ((PROD_W+1)'(1) << QUO_BITS) : (PROD_W+1)'(q1);
    if (is_div) begin
      c = clip_mag(p.neg, mag);
    end else begin
      c.sat = p.sat;
      c.val = p.res;
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/complex_arithmetic_unit.sv =====
// Complex arithmetic unit: a fully pipelined complex ALU on signed fixed-point operands.
// The result strobe is registered at the end of the pipeline, behind the division stages and the output stage.
// Throughput: one command per cycle; busy is always low and the pipeline never stalls.
// The 32 stages of bit-serial restoring division set the depth, for every opcode alike.
// Reset (synchronous, active low) clears all valid bits; data registers are not reset.
module complex_arithmetic_unit
  import cau_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [2:0]               in_cmd,
  input  logic signed [DATA_W-1:0] in_a_real,
  input  logic signed [DATA_W-1:0] in_a_imag,
  input  logic signed [DATA_W-1:0] in_b_real,
  input  logic signed [DATA_W-1:0] in_b_imag,
  input  logic signed [DATA_W-1:0] in_real_factor,
  output logic                     out_strobe,
  output logic signed [DATA_W-1:0] out_res_real,
  output logic signed [DATA_W-1:0] out_res_imag,
  output logic                     out_div_zero,
  output logic                     out_saturated
);

  // Valid bits of the front stages.
  logic v1_r, v2_r, v3_r, v4_r;
  logic [QUO_BITS:0] dv_r;
  logic out_strobe_r;

  // Stage 1: input registers.
  logic [2:0] s1_cmd_r;
  logic signed [DATA_W-1:0] s1_ar_r, s1_ai_r, s1_br_r, s1_bi_r, s1_f_r;

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      s1_cmd_r <= in_cmd;
      s1_ar_r  <= in_a_real;
      s1_ai_r  <= in_a_imag;
      s1_br_r  <= in_b_real;
      s1_bi_r  <= in_b_imag;
      s1_f_r   <= in_real_factor;
    end
  end

  // Stage 2: six products, with the first two operands picked by opcode.
  logic signed [DATA_W-1:0] mul0_b, mul1_b;
  logic [2:0] s2_cmd_r;
  logic signed [DATA_W-1:0] s2_ar_r, s2_ai_r, s2_br_r, s2_bi_r, s2_f_r;
  logic signed [PROD_W-1:0] s2_m0_r, s2_m1_r, s2_m2_r, s2_m3_r, s2_m4_r, s2_m5_r;

  always_comb begin
    mul0_b = s1_br_r;
    mul1_b = s1_bi_r;
    if (s1_cmd_r == OP_SCALE) begin
      mul0_b = s1_f_r;
      mul1_b = s1_f_r;
    end else if (s1_cmd_r == OP_MOD_SQ) begin
      mul0_b = s1_ar_r;
      mul1_b = s1_ai_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_cmd_r <= s1_cmd_r;
    s2_ar_r  <= s1_ar_r;
    s2_ai_r  <= s1_ai_r;
    s2_br_r  <= s1_br_r;
    s2_bi_r  <= s1_bi_r;
    s2_f_r   <= s1_f_r;
    s2_m0_r  <= s1_ar_r * mul0_b;
    s2_m1_r  <= s1_ai_r * mul1_b;
    s2_m2_r  <= s1_ar_r * s1_bi_r;
    s2_m3_r  <= s1_ai_r * s1_br_r;
    s2_m4_r  <= s1_br_r * s1_br_r;
    s2_m5_r  <= s1_bi_r * s1_bi_r;
  end

  // Stage 3: exact sums of the products, divisor and finishing mode.
  logic signed [PROD_W:0] sr_nxt, si_nxt;
  logic [PROD_W-1:0] den_nxt;
  logic [1:0] mode_nxt;
  logic dz_nxt, fneg_nxt;
  logic signed [PROD_W:0] s3_sr_r, s3_si_r;
  logic [PROD_W-1:0] s3_den_r;
  logic [1:0] s3_mode_r;
  logic s3_dz_r, s3_fneg_r, s3_cplx_r;

  always_comb begin
    sr_nxt   = '0;
    si_nxt   = '0;
    den_nxt  = s2_f_r[DATA_W-1] ? -(PROD_W'(s2_f_r)) : PROD_W'(s2_f_r);
    mode_nxt = MODE_CLIP;
    dz_nxt   = 1'b0;
    fneg_nxt = 1'b0;
    unique case (s2_cmd_r)
      OP_ADD: begin
        sr_nxt = (PROD_W+1)'(s2_ar_r) + (PROD_W+1)'(s2_br_r);
        si_nxt = (PROD_W+1)'(s2_ai_r) + (PROD_W+1)'(s2_bi_r);
      end
      OP_SUB: begin
        sr_nxt = (PROD_W+1)'(s2_ar_r) - (PROD_W+1)'(s2_br_r);
        si_nxt = (PROD_W+1)'(s2_ai_r) - (PROD_W+1)'(s2_bi_r);
      end
      OP_MUL: begin
        sr_nxt   = (PROD_W+1)'(s2_m0_r) - (PROD_W+1)'(s2_m1_r);
        si_nxt   = (PROD_W+1)'(s2_m2_r) + (PROD_W+1)'(s2_m3_r);
        mode_nxt = MODE_SCALE;
      end
      OP_SCALE: begin
        sr_nxt   = (PROD_W+1)'(s2_m0_r);
        si_nxt   = (PROD_W+1)'(s2_m1_r);
        mode_nxt = MODE_SCALE;
      end
      OP_DIV_REAL: begin
        sr_nxt   = (PROD_W+1)'(s2_ar_r);
        si_nxt   = (PROD_W+1)'(s2_ai_r);
        mode_nxt = MODE_DIV;
        dz_nxt   = (s2_f_r == '0);
        fneg_nxt = s2_f_r[DATA_W-1];
      end
      OP_DIV_CPLX: begin
        sr_nxt   = (PROD_W+1)'(s2_m0_r) + (PROD_W+1)'(s2_m1_r);
        si_nxt   = (PROD_W+1)'(s2_m3_r) - (PROD_W+1)'(s2_m2_r);
        den_nxt  = PROD_W'(s2_m4_r) + PROD_W'(s2_m5_r);
        mode_nxt = MODE_DIV;
      end
      OP_CONJ: begin
        sr_nxt = (PROD_W+1)'(s2_ar_r);
        si_nxt = -(PROD_W+1)'(s2_ai_r);
      end
      OP_MOD_SQ: begin
        sr_nxt   = (PROD_W+1)'(s2_m0_r) + (PROD_W+1)'(s2_m1_r);
        mode_nxt = MODE_SCALE;
      end
      default: begin
        sr_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    s3_sr_r   <= sr_nxt;
    s3_si_r   <= si_nxt;
    s3_den_r  <= den_nxt;
    s3_mode_r <= mode_nxt;
    s3_dz_r   <= dz_nxt;
    s3_fneg_r <= fneg_nxt;
    s3_cplx_r <= (s2_cmd_r == OP_DIV_CPLX);
  end

  // Stage 4: sign and magnitude of both parts.
  logic s4_nr_r, s4_ni_r, s4_dz_r;
  logic [PROD_W-1:0] s4_mr_r, s4_mi_r, s4_den_r;
  logic [1:0] s4_mode_r;
  logic [PROD_W-1:0] mr_nxt, mi_nxt;

  assign mr_nxt = s3_sr_r[PROD_W] ? PROD_W'(-s3_sr_r) : s3_sr_r[PROD_W-1:0];
  assign mi_nxt = s3_si_r[PROD_W] ? PROD_W'(-s3_si_r) : s3_si_r[PROD_W-1:0];

  always_ff @(posedge clk) begin
    s4_mr_r   <= mr_nxt;
    s4_mi_r   <= mi_nxt;
    s4_nr_r   <= s3_sr_r[PROD_W] ^ (s3_fneg_r && (mr_nxt != '0));
    s4_ni_r   <= s3_si_r[PROD_W] ^ (s3_fneg_r && (mi_nxt != '0));
    s4_den_r  <= s3_den_r;
    s4_mode_r <= s3_mode_r;
    s4_dz_r   <= s3_dz_r || (s3_cplx_r && (s3_den_r == '0));
  end

  // Stage 5: early results for the simple modes, divider setup for the others.
  function automatic part_t part_setup(input logic neg, input logic [PROD_W-1:0] mag,
                                       input logic [1:0] mode,
                                       input logic [PROD_W-1:0] den);
    part_t           p;
    clip_t           c;
    logic [PROD_W:0] rounded;
    rounded = ({1'b0, mag} + ((PROD_W+1)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    c       = (mode == MODE_SCALE) ? clip_mag(neg, rounded) : clip_mag(neg, {1'b0, mag});
    p.neg    = neg;
    p.presat = (WIDE_W'(mag) >= (WIDE_W'(den) << DIV_SHIFT));
    p.sat    = c.sat;
    p.res    = c.val;
    p.rem    = mag >> DIV_SHIFT;
    p.quo    = '0;
    p.low    = QUO_BITS'(mag << FRAC_BITS);
    return p;
  endfunction

  div_stage_t stage_r [QUO_BITS+1];

  always_ff @(posedge clk) begin
    stage_r[0].dz     <= s4_dz_r;
    stage_r[0].is_div <= (s4_mode_r == MODE_DIV);
    stage_r[0].den    <= s4_den_r;
    stage_r[0].re     <= part_setup(s4_nr_r, s4_mr_r, s4_mode_r, s4_den_r);
    stage_r[0].im     <= part_setup(s4_ni_r, s4_mi_r, s4_mode_r, s4_den_r);
  end

  // Division stages: one quotient bit per stage for both parts.
  for (genvar k = 1; k <= QUO_BITS; k++) begin : g_div
    always_ff @(posedge clk) begin
      stage_r[k] <= div_step(stage_r[k-1]);
    end
  end

  // Output stage: rounding, saturation and the zero-divisor override.
  clip_t fin_re, fin_im;
  logic signed [DATA_W-1:0] res_real_r, res_imag_r;
  logic div_zero_r, saturated_r;

  assign fin_re = part_finish(stage_r[QUO_BITS].re, stage_r[QUO_BITS].is_div,
                              stage_r[QUO_BITS].den);
  assign fin_im = part_finish(stage_r[QUO_BITS].im, stage_r[QUO_BITS].is_div,
                              stage_r[QUO_BITS].den);

  always_ff @(posedge clk) begin
    div_zero_r <= stage_r[QUO_BITS].dz;
    if (stage_r[QUO_BITS].dz) begin
      res_real_r  <= '0;
      res_imag_r  <= '0;
      saturated_r <= 1'b0;
    end else begin
      res_real_r  <= fin_re.val;
      res_imag_r  <= fin_im.val;
      saturated_r <= fin_re.sat | fin_im.sat;
    end
  end

  // Valid bits travel alongside the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
      v4_r         <= 1'b0;
      dv_r         <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      v1_r         <= start && !busy;
      v2_r         <= v1_r;
      v3_r         <= v2_r;
      v4_r         <= v3_r;
      dv_r         <= {dv_r[QUO_BITS-1:0], v4_r};
      out_strobe_r <= dv_r[QUO_BITS];
    end
  end

  assign busy          = 1'b0;
  assign out_strobe    = out_strobe_r;
  assign out_res_real  = res_real_r;
  assign out_res_imag  = res_imag_r;
  assign out_div_zero  = div_zero_r;
  assign out_saturated = saturated_r;

  // A result always stems from a command transferred a fixed time earlier.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy && rst_n, LATENCY))
    else $error("result strobe without a matching command");

  // A zero divisor gives a zero result and no saturation.
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_div_zero) |->
      (out_res_real == '0 && out_res_imag == '0 && !out_saturated))
    else $error("zero-divisor result not cleared");

  // Only the two divide opcodes can flag a zero divisor.
  a_dz_op: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && $past(in_cmd, LATENCY) != OP_DIV_REAL &&
     $past(in_cmd, LATENCY) != OP_DIV_CPLX) |-> !out_div_zero)
    else $error("zero-divisor flag on a non-divide command");

  // Modulus squared has a zero imaginary part.
  a_mod_imag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && $past(in_cmd, LATENCY) == OP_MOD_SQ) |-> out_res_imag == '0)
    else $error("modulus squared with nonzero imaginary part");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the complex arithmetic unit, with a bit-exact predictor.
`timescale 1ns / 1ps

module tb_top
  import cau_pkg::*;
();

  typedef struct {
    logic [2:0]         cmd;
    logic signed [31:0] ar, ai, br, bi, f;
  } cmd_item_t;

  typedef struct {
    logic [31:0] re, im;
    logic        dz, sat;
  } cplx_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] in_cmd = '0;
  logic signed [31:0] in_a_real = '0, in_a_imag = '0, in_b_real = '0, in_b_imag = '0;
  logic signed [31:0] in_real_factor = '0;
  logic out_strobe, out_div_zero, out_saturated;
  logic signed [31:0] out_res_real, out_res_imag;

  cmd_item_t    pending_cmds[$];
  cplx_result_t awaited_results[$];
  int           idle_pct = 0;
  bit           failed = 1'b0;

  complex_arithmetic_unit uut (.*);

  // Clock with a 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Clip an exact value to the signed 32-bit range.
  function automatic logic [31:0] sat32(input logic signed [127:0] v, inout logic s);
    if (v > 128'sh7FFFFFFF) begin
      s = 1'b1;
      return 32'h7FFFFFFF;
    end
    if (v < -128'sh80000000) begin
      s = 1'b1;
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  // Drop the fraction bits of a product, rounding ties away from zero.
  function automatic logic signed [127:0] round_product(input logic signed [127:0] v);
    logic [127:0] mag;
    mag = v < 0 ? -v : v;
    mag = (mag + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return v < 0 ? -$signed(mag) : $signed(mag);
  endfunction

  // Fixed-point quotient v / d, rounded to nearest with ties away from zero.
  function automatic logic signed [127:0] round_quotient(input logic signed [127:0] v,
                                                         input logic signed [127:0] d);
    logic [127:0] nmag, dmag, q, r;
    logic         neg;
    nmag = v < 0 ? -v : v;
    dmag = d < 0 ? -d : d;
    neg  = ((v < 0) != (d < 0)) && (nmag != 0);
    q    = (nmag << FRAC_BITS) / dmag;
    r    = (nmag << FRAC_BITS) % dmag;
    if (r >= dmag - r) q = q + 1;
    return neg ? -$signed(q) : $signed(q);
  endfunction

  // Expected result of one command.
  function automatic cplx_result_t predict_cplx(input cmd_item_t c);
    cplx_result_t       e;
    logic signed [127:0] xar, xai, xbr, xbi, xf, den;
    logic               s;
    xar = c.ar; xai = c.ai; xbr = c.br; xbi = c.bi; xf = c.f;
    s = 1'b0;
    e.dz = 1'b0;
    e.re = '0;
    e.im = '0;
    case (c.cmd)
      OP_ADD: begin
        e.re = sat32(xar + xbr, s);
        e.im = sat32(xai + xbi, s);
      end
      OP_SUB: begin
        e.re = sat32(xar - xbr, s);
        e.im = sat32(xai - xbi, s);
      end
      OP_MUL: begin
        e.re = sat32(round_product(xar * xbr - xai * xbi), s);
        e.im = sat32(round_product(xar * xbi + xai * xbr), s);
      end
      OP_SCALE: begin
        e.re = sat32(round_product(xar * xf), s);
        e.im = sat32(round_product(xai * xf), s);
      end
      OP_DIV_REAL: begin
        if (xf == 0) e.dz = 1'b1;
        else begin
          e.re = sat32(round_quotient(xar, xf), s);
          e.im = sat32(round_quotient(xai, xf), s);
        end
      end
      OP_DIV_CPLX: begin
        den = xbr * xbr + xbi * xbi;
        if (den == 0) e.dz = 1'b1;
        else begin
          e.re = sat32(round_quotient(xar * xbr + xai * xbi, den), s);
          e.im = sat32(round_quotient(xai * xbr - xar * xbi, den), s);
        end
      end
      OP_CONJ: begin
        e.re = sat32(xar, s);
        e.im = sat32(-xai, s);
      end
      default: begin
        e.re = sat32(round_product(xar * xar + xai * xai), s);
      end
    endcase
    e.sat = s;
    return e;
  endfunction

  // Operand mix: full range, small and medium magnitudes, zero and the extremes.
  function automatic logic signed [31:0] rand_operand();
    case ($urandom_range(0, 6))
      0, 1: return $urandom;
      2: return int'($urandom_range(0, 1 << 21)) - (1 << 20);
      3: return int'($urandom_range(0, 1 << 25)) - (1 << 24);
      4: return 32'sd0;
      5: return 32'sh7FFFFFFF;
      default: return 32'sh80000000;
    endcase
  endfunction

  task automatic queue_cmd(input logic [2:0] cmd, input logic signed [31:0] ar, ai, br, bi, f);
    cmd_item_t c;
    c.cmd = cmd; c.ar = ar; c.ai = ai; c.br = br; c.bi = bi; c.f = f;
    pending_cmds.push_back(c);
  endtask

  task automatic queue_random(input int count);
    cmd_item_t c;
    repeat (count) begin
      c.cmd = 3'($urandom_range(0, 7));
      c.ar = rand_operand(); c.ai = rand_operand();
      c.br = rand_operand(); c.bi = rand_operand();
      c.f  = rand_operand();
      pending_cmds.push_back(c);
    end
  endtask

  task automatic drain();
    while (pending_cmds.size() != 0 || awaited_results.size() != 0) @(posedge clk);
  endtask

  // Driver: presents the oldest pending command at the falling edge unless idling.
  always @(negedge clk) begin
    if (rst_n && pending_cmds.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
      start          <= 1'b1;
      in_cmd         <= pending_cmds[0].cmd;
      in_a_real      <= pending_cmds[0].ar;
      in_a_imag      <= pending_cmds[0].ai;
      in_b_real      <= pending_cmds[0].br;
      in_b_imag      <= pending_cmds[0].bi;
      in_real_factor <= pending_cmds[0].f;
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: records each command transfer and checks each result transfer.
  always @(posedge clk) begin
    cplx_result_t e;
    if (rst_n) begin
      if (start && !busy) begin
        awaited_results.push_back(predict_cplx(pending_cmds.pop_front()));
      end
      if (out_strobe) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result re=%h im=%h", $time, out_res_real, out_res_imag);
          failed = 1'b1;
        end else begin
          e = awaited_results.pop_front();
          if (out_res_real !== e.re || out_res_imag !== e.im ||
              out_div_zero !== e.dz || out_saturated !== e.sat) begin
            $display("%0t: expected re=%h im=%h dz=%b sat=%b, got re=%h im=%h dz=%b sat=%b",
                     $time, e.re, e.im, e.dz, e.sat,
                     out_res_real, out_res_imag, out_div_zero, out_saturated);
            failed = 1'b1;
          end
        end
      end
    end
  end

  // Stimulus phases and end of run.
  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // Directed: extremes, every opcode, zero divisors, rounding ties.
    queue_cmd(OP_ADD, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 0);
    queue_cmd(OP_ADD, 32'sh10000, -32'sh10000, 32'sh20000, 32'sh30000, 0);
    queue_cmd(OP_SUB, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 0);
    queue_cmd(OP_SUB, 32'sh50000, 32'sh1, 32'sh20000, 32'sh2, 0);
    queue_cmd(OP_MUL, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0);
    queue_cmd(OP_MUL, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 0);
    queue_cmd(OP_MUL, 32'sh1, 32'sh0, 32'sh8000, 32'sh0, 0);
    queue_cmd(OP_MUL, -32'sh1, 32'sh0, 32'sh8000, 32'sh0, 0);
    queue_cmd(OP_SCALE, 32'sh18000, -32'sh28000, 0, 0, 32'sh8000);
    queue_cmd(OP_SCALE, 32'sh80000000, 32'sh7FFFFFFF, 0, 0, 32'sh80000000);
    queue_cmd(OP_DIV_REAL, 32'sh10000, 32'sh20000, 0, 0, 32'sh0);
    queue_cmd(OP_DIV_REAL, 32'sh10000, -32'sh10000, 0, 0, 32'sh30000);
    queue_cmd(OP_DIV_REAL, 32'sh7FFFFFFF, 32'sh80000000, 0, 0, 32'sh1);
    queue_cmd(OP_DIV_REAL, 32'sh1, -32'sh1, 0, 0, 32'sh20000);
    queue_cmd(OP_DIV_CPLX, 32'sh10000, 32'sh10000, 32'sh0, 32'sh0, 0);
    queue_cmd(OP_DIV_CPLX, 32'sh30000, -32'sh20000, 32'sh10000, 32'sh20000, 0);
    queue_cmd(OP_DIV_CPLX, 32'sh7FFFFFFF, 32'sh80000000, 32'sh1, 32'sh0, 0);
    queue_cmd(OP_DIV_CPLX, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 0);
    queue_cmd(OP_CONJ, 32'sh80000000, 32'sh80000000, 0, 0, 0);
    queue_cmd(OP_CONJ, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 0, 0);
    queue_cmd(OP_MOD_SQ, 32'sh80000000, 32'sh80000000, 0, 0, 0);
    queue_cmd(OP_MOD_SQ, 32'sh18000, -32'sh8000, 0, 0, 0);
    drain();

    // Random phases with different sender idling.
    idle_pct = 0;  queue_random(400); drain();
    idle_pct = 77; queue_random(250); drain();
    idle_pct = 0;  queue_random(300); drain();
    idle_pct = 21; queue_random(250); drain();

    repeat (LATENCY + 10) @(posedge clk);
    if (!failed && awaited_results.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // Timeout.
  initial begin
    #2ms;
    $display("tb_top failed");
    $finish;
  end

endmodule
